// File: hdl/pub_pkg.sv
// Shared types and constants for the picture unit background renderer.
package pub_pkg;

  localparam int PATTERN_BYTES = 8192;
  localparam int SPRITE_BYTES  = 256;
  localparam int PAT_AW        = 13;
  localparam int SPR_AW        = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMA   = 3'd3;
  localparam logic [2:0] REG_OAMD   = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [14:0] VERT_BITS  = 15'h7BE0;
  localparam logic [14:0] HORZ_BITS  = 15'h041F;
  localparam logic [11:0] ATTR_BASE  = 12'h3C0;
  localparam logic [13:0] PAL_START  = 14'h3F00;
  localparam logic [13:0] NT_START   = 14'h2000;
  localparam logic [5:0]  BORDER_COL = 6'd13;

  // result kind of the request held in the second stage
  typedef enum logic [1:0] {
    RK_DIRECT = 2'd0,
    RK_STATUS = 2'd1,
    RK_SPRITE = 2'd2,
    RK_DATA   = 2'd3
  } rkind_t;

  // source of a value fetched for the read buffer
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_PAT  = 2'd1,
    SRC_NAME = 2'd2,
    SRC_PAL  = 2'd3
  } src_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        pixel_valid;
    logic [5:0]  pixel_color;
    logic [15:0] pixel_position;
    logic        nmi;
    logic        frame_done;
  } rsp_t;

  function automatic logic [4:0] pal_idx(input logic [4:0] a);
    logic [4:0] r;
    r = a;
    if (a[4] && a[1:0] == 2'b00) begin
      r[4] = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/pub_ram.sv
// Generic simple dual-port RAM with registered read.
module pub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/picture_unit_bus_and_background_render_top.sv
// Top level of the picture unit: register bus, dot timing and background render.
//
//  port group | direction | handshake        | payload
//  in_        | input     | in_valid/ready   | in_req  (op, reg_index, write_data)
//  out_       | output    | out_valid/ready  | out_rsp (read data, pixel, nmi, frame)
//  cfg_       | input     | cfg_we           | cfg_wdata (mirroring)
//
// One request per cycle while in_ready is high: stage 0 updates the registers and
// issues RAM reads; stage 1 takes the read data next cycle, presents the result.
// After reset a clearing pass zeroes pattern, nametable and sprite RAM; in_ready
// stays low during it, cfg writes are taken throughout.
// A stalled result holds stage 1; in_ready then follows out_ready.
module picture_unit_bus_and_background_render_top #(
  parameter int NAME_RAM_BYTES = 2048
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pub_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output pub_pkg::rsp_t out_rsp,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import pub_pkg::*;

  localparam int NA_W = $clog2(NAME_RAM_BYTES);

  function automatic logic [NA_W-1:0] nt_idx(input logic [11:0] a, input logic m);
    logic [11:0] full;
    full = {1'b0, (m ? a[10] : a[11]), a[9:0]};
    return full[NA_W-1:0];
  endfunction

  // architectural state
  logic        mirror_r;
  logic [7:0]  ctrl_r, ctrl_nxt, mask_r, mask_nxt, status_r, status_nxt;
  logic [7:0]  spr_addr_r, spr_addr_nxt;
  logic        second_r, second_nxt;
  logic [14:0] vaddr_r, vaddr_nxt, taddr_r, taddr_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic [7:0]  dbuf_r;
  logic [7:0]  pal_r [32];
  logic        pal_we;
  logic [4:0]  pal_wa;
  logic [8:0]  dot_r, dot_nxt, line_r, line_nxt;
  logic        odd_r, odd_nxt;
  logic [15:0] bgl_r, bgl_nxt, bgh_r, bgh_nxt, atl_r, atl_nxt, ath_r, ath_nxt;
  logic [7:0]  latch_r [4];
  logic [2:0]  quad_r, quad_nxt;
  logic [15:0] pixcnt_r, pixcnt_nxt;

  // clearing pass
  logic             clr_busy_r;
  logic [PAT_AW-1:0] clr_addr_r;

  // stage 1
  logic        s1_valid_r;
  rkind_t      s1_kind_r, s1_kind_nxt;
  logic [7:0]  s1_rd_r, s1_rd_nxt, s1_pal_r, s1_pal_nxt;
  src_t        s1_src_r, s1_src_nxt;
  logic        s1_lwe_r, s1_lwe_nxt;
  logic [1:0]  s1_lidx_r, s1_lidx_nxt;
  logic        s1_pv_r, s1_pv_nxt, s1_nmi_r, s1_nmi_nxt, s1_fd_r, s1_fd_nxt;
  logic [5:0]  s1_col_r, s1_col_nxt;
  logic [15:0] s1_pos_r, s1_pos_nxt;

  // RAM ports
  logic              pat_we, pat_re, nt_we, nt_re, spr_we, spr_re;
  logic [PAT_AW-1:0] pat_wa, pat_ra;
  logic [NA_W-1:0]   nt_wa, nt_ra;
  logic [SPR_AW-1:0] spr_a;
  logic [7:0]        ram_wd, pat_rd, nt_rd, spr_rd;

  logic accept, leave;
  logic [7:0] newval;

  assign in_ready  = !clr_busy_r && (!s1_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = s1_valid_r;
  assign leave     = s1_valid_r && out_ready;

  pub_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat (
    .clk(clk), .we(pat_we), .waddr(pat_wa), .wdata(ram_wd),
    .re(pat_re), .raddr(pat_ra), .rdata(pat_rd)
  );
  pub_ram #(.WIDTH(8), .DEPTH(NAME_RAM_BYTES)) u_nt (
    .clk(clk), .we(nt_we), .waddr(nt_wa), .wdata(ram_wd),
    .re(nt_re), .raddr(nt_ra), .rdata(nt_rd)
  );
  pub_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_spr (
    .clk(clk), .we(spr_we), .waddr(spr_a), .wdata(ram_wd),
    .re(spr_re), .raddr(spr_a), .rdata(spr_rd)
  );

  // stage 0
  always_comb begin
    logic [8:0]  d;
    logic [8:0]  l;
    logic        pre, rend, in_rng;
    logic [14:0] v;
    logic [13:0] a;
    logic [4:0]  cy;
    logic [7:0]  at;
    logic [3:0]  idx;
    logic [5:0]  p;
    logic [7:0]  wd;
    logic [2:0]  ri;

    ctrl_nxt = ctrl_r; mask_nxt = mask_r; status_nxt = status_r;
    spr_addr_nxt = spr_addr_r; second_nxt = second_r;
    vaddr_nxt = vaddr_r; taddr_nxt = taddr_r; fine_x_nxt = fine_x_r;
    dot_nxt = dot_r; line_nxt = line_r; odd_nxt = odd_r;
    bgl_nxt = bgl_r; bgh_nxt = bgh_r; atl_nxt = atl_r; ath_nxt = ath_r;
    quad_nxt = quad_r; pixcnt_nxt = pixcnt_r;
    pal_we = 1'b0; pal_wa = '0;
    pat_we = 1'b0; pat_re = 1'b0; pat_wa = vaddr_r[PAT_AW-1:0]; pat_ra = '0;
    nt_we = 1'b0; nt_re = 1'b0; nt_wa = '0; nt_ra = '0;
    spr_we = 1'b0; spr_re = 1'b0; spr_a = spr_addr_r;
    ram_wd = in_req.write_data;
    s1_kind_nxt = RK_DIRECT; s1_rd_nxt = '0; s1_pal_nxt = '0; s1_src_nxt = SRC_NONE;
    s1_lwe_nxt = 1'b0; s1_lidx_nxt = '0;
    s1_pv_nxt = 1'b0; s1_col_nxt = '0; s1_pos_nxt = '0; s1_nmi_nxt = 1'b0; s1_fd_nxt = 1'b0;

    wd   = in_req.write_data;
    ri   = in_req.reg_index;
    v    = vaddr_r;
    a    = vaddr_r[13:0];
    d    = dot_r;
    l    = line_r;
    pre  = (line_r == 9'd261);
    rend = mask_r[4] || mask_r[3];
    in_rng = 1'b0;
    cy = '0; at = '0; idx = '0; p = '0;

    if (clr_busy_r) begin
      pat_we = 1'b1; nt_we = 1'b1; spr_we = 1'b1; ram_wd = '0;
      pat_wa = clr_addr_r;
      nt_wa  = clr_addr_r[NA_W-1:0];
      spr_a  = clr_addr_r[SPR_AW-1:0];
    end else if (accept) begin
      case (op_t'(in_req.op))
        OP_READ: begin
          unique case (ri)
            REG_STATUS: begin
              s1_kind_nxt = RK_STATUS;
              s1_rd_nxt = status_r;
              status_nxt[7] = 1'b0;
              second_nxt = 1'b0;
            end
            REG_OAMD: begin
              s1_kind_nxt = RK_SPRITE;
              spr_re = 1'b1;
            end
            REG_DATA: begin
              s1_kind_nxt = RK_DATA;
              if (a < NT_START) begin
                pat_re = 1'b1; pat_ra = a[PAT_AW-1:0]; s1_src_nxt = SRC_PAT;
              end else if (a < PAL_START) begin
                nt_re = 1'b1; nt_ra = nt_idx(a[11:0], mirror_r); s1_src_nxt = SRC_NAME;
              end else begin
                s1_pal_nxt = pal_r[pal_idx(a[4:0])]; s1_src_nxt = SRC_PAL;
              end
              vaddr_nxt = vaddr_r + (ctrl_r[2] ? 15'd32 : 15'd1);
            end
            default: s1_kind_nxt = RK_DIRECT;
          endcase
        end
        OP_WRITE: begin
          status_nxt[4:0] = wd[4:0];
          unique case (ri)
            REG_CTRL: begin
              ctrl_nxt = wd;
              taddr_nxt[11:10] = wd[1:0];
            end
            REG_MASK: mask_nxt = wd;
            REG_OAMA: spr_addr_nxt = wd;
            REG_OAMD: spr_we = 1'b1;
            REG_SCROLL: begin
              if (!second_r) begin
                fine_x_nxt = wd[2:0];
                taddr_nxt[4:0] = wd[7:3];
              end else begin
                taddr_nxt[14:12] = wd[2:0];
                taddr_nxt[9:5] = wd[7:3];
              end
              second_nxt = !second_r;
            end
            REG_ADDR: begin
              if (!second_r) begin
                taddr_nxt = {1'b0, wd[5:0], taddr_r[7:0]};
              end else begin
                taddr_nxt = {taddr_r[14:8], wd};
                vaddr_nxt = {taddr_r[14:8], wd};
              end
              second_nxt = !second_r;
            end
            REG_DATA: begin
              if (a < NT_START) begin
                pat_we = 1'b1;
              end else if (a < PAL_START) begin
                nt_we = 1'b1; nt_wa = nt_idx(a[11:0], mirror_r);
              end else begin
                pal_we = 1'b1; pal_wa = pal_idx(a[4:0]);
              end
              vaddr_nxt = vaddr_r + (ctrl_r[2] ? 15'd32 : 15'd1);
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (pre || l <= 9'd239) begin
            if (pre && d == 9'd1) begin
              pixcnt_nxt = '0;
              status_nxt[7:5] = 3'b000;
            end
            if (pre && d >= 9'd280 && d <= 9'd304 && rend) begin
              v = (v & ~VERT_BITS) | (taddr_r & VERT_BITS);
            end
            if (l == 9'd0 && d == 9'd0 && odd_r) begin
              d = 9'd1;
            end
            if (d == 9'd257 && rend) begin
              v = (v & ~HORZ_BITS) | (taddr_r & HORZ_BITS);
            end
            in_rng = (d >= 9'd1 && d <= 9'd257) || (d >= 9'd321 && d <= 9'd337);
            if (in_rng) begin
              if (rend && d != 9'd321) begin
                bgl_nxt = {bgl_r[14:0], 1'b0};
                bgh_nxt = {bgh_r[14:0], 1'b0};
                atl_nxt = {atl_r[14:0], 1'b0};
                ath_nxt = {ath_r[14:0], 1'b0};
                if (d[2:0] == 3'd1) begin
                  at = latch_r[1] >> quad_r;
                  bgl_nxt[7:0] = latch_r[2];
                  bgh_nxt[7:0] = latch_r[3];
                  atl_nxt[7:0] = {8{at[0]}};
                  ath_nxt[7:0] = {8{at[1]}};
                end
              end
              if (!pre && d >= 9'd2 && d <= 9'd257) begin
                pixcnt_nxt = pixcnt_r + 16'd1;
                if (rend) begin
                  idx = {ath_nxt[{1'b1, ~fine_x_r}], atl_nxt[{1'b1, ~fine_x_r}],
                         bgh_nxt[{1'b1, ~fine_x_r}], bgl_nxt[{1'b1, ~fine_x_r}]};
                  if (!mask_r[3] || idx[1:0] == 2'b00) begin
                    idx = '0;
                  end
                  p = pal_r[{1'b0, idx}][5:0];
                  if (mask_r[0]) begin
                    p = p & 6'h30;
                  end
                  if (d <= 9'd9 || d >= 9'd249 || l <= 9'd7 || l >= 9'd232) begin
                    p = BORDER_COL;
                  end
                  s1_pv_nxt = 1'b1;
                  s1_col_nxt = p;
                  s1_pos_nxt = pixcnt_r;
                end
              end
              if (rend) begin
                case (d[2:0])
                  3'd1: begin
                    nt_re = 1'b1; nt_ra = nt_idx(v[11:0], mirror_r);
                    s1_lwe_nxt = 1'b1; s1_lidx_nxt = 2'd0;
                  end
                  3'd3: begin
                    nt_re = 1'b1;
                    nt_ra = nt_idx({v[11:10], ATTR_BASE[9:0] | {4'b0, v[9:7], v[4:2]}},
                                   mirror_r);
                    quad_nxt = {v[6], v[1], 1'b0};
                    s1_lwe_nxt = 1'b1; s1_lidx_nxt = 2'd1;
                  end
                  3'd5: begin
                    pat_re = 1'b1; pat_ra = {ctrl_r[4], latch_r[0], 1'b0, v[14:12]};
                    s1_lwe_nxt = 1'b1; s1_lidx_nxt = 2'd2;
                  end
                  3'd7: begin
                    pat_re = 1'b1; pat_ra = {ctrl_r[4], latch_r[0], 1'b1, v[14:12]};
                    s1_lwe_nxt = 1'b1; s1_lidx_nxt = 2'd3;
                  end
                  3'd0: begin
                    if (d == 9'd256) begin
                      if (v[14:12] != 3'd7) begin
                        v = v + 15'h1000;
                      end else begin
                        v[14:12] = 3'd0;
                        cy = v[9:5];
                        if (cy == 5'd29) begin
                          cy = '0;
                          v[11] = ~v[11];
                        end else if (cy == 5'd31) begin
                          cy = '0;
                        end else begin
                          cy = cy + 5'd1;
                        end
                        v[9:5] = cy;
                      end
                    end
                    if (v[4:0] == 5'd31) begin
                      v[4:0] = '0;
                      v[10] = ~v[10];
                    end else begin
                      v = v + 15'd1;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end else if (l == 9'd241 && d == 9'd1) begin
            status_nxt[7] = 1'b1;
            s1_fd_nxt = 1'b1;
            s1_nmi_nxt = ctrl_r[7];
          end
          vaddr_nxt = v;
          if (d >= 9'd340) begin
            dot_nxt = '0;
            if (l >= 9'd261) begin
              line_nxt = '0;
              odd_nxt = !odd_r;
            end else begin
              line_nxt = l + 9'd1;
            end
          end else begin
            dot_nxt = d + 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // stage 1 result
  always_comb begin
    case (s1_src_r)
      SRC_PAT:  newval = pat_rd;
      SRC_NAME: newval = nt_rd;
      default:  newval = s1_pal_r;
    endcase
    out_rsp = '0;
    unique case (s1_kind_r)
      RK_STATUS: out_rsp.read_data = {s1_rd_r[7:5], dbuf_r[4:0]};
      RK_SPRITE: out_rsp.read_data = spr_rd;
      RK_DATA:   out_rsp.read_data = (s1_src_r == SRC_PAL) ? newval : dbuf_r;
      default:   out_rsp.read_data = s1_rd_r;
    endcase
    out_rsp.pixel_valid    = s1_pv_r;
    out_rsp.pixel_color    = s1_col_r;
    out_rsp.pixel_position = s1_pos_r;
    out_rsp.nmi            = s1_nmi_r;
    out_rsp.frame_done     = s1_fd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
      ctrl_r <= '0; mask_r <= '0; status_r <= '0; spr_addr_r <= '0;
      second_r <= 1'b0; vaddr_r <= '0; taddr_r <= '0; fine_x_r <= '0;
      dbuf_r <= '0; dot_r <= '0; line_r <= '0; odd_r <= 1'b0;
      bgl_r <= '0; bgh_r <= '0; atl_r <= '0; ath_r <= '0;
      quad_r <= '0; pixcnt_r <= '0;
      for (int i = 0; i < 32; i++) pal_r[i] <= '0;
      for (int i = 0; i < 4; i++) latch_r[i] <= '0;
      clr_busy_r <= 1'b1; clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mirror_r <= cfg_wdata;
      end
      ctrl_r <= ctrl_nxt; mask_r <= mask_nxt; status_r <= status_nxt;
      spr_addr_r <= spr_addr_nxt; second_r <= second_nxt;
      vaddr_r <= vaddr_nxt; taddr_r <= taddr_nxt; fine_x_r <= fine_x_nxt;
      dot_r <= dot_nxt; line_r <= line_nxt; odd_r <= odd_nxt;
      bgl_r <= bgl_nxt; bgh_r <= bgh_nxt; atl_r <= atl_nxt; ath_r <= ath_nxt;
      quad_r <= quad_nxt; pixcnt_r <= pixcnt_nxt;
      if (pal_we) begin
        pal_r[pal_wa] <= in_req.write_data;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clr_busy_r <= 1'b0;
        end
      end
      // retire stage 1: commit fetched bytes
      if (leave) begin
        if (s1_src_r != SRC_NONE) begin
          dbuf_r <= newval;
        end
        if (s1_lwe_r) begin
          latch_r[s1_lidx_r] <= s1_lidx_r[1] ? pat_rd : nt_rd;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= s1_kind_nxt; s1_rd_r <= s1_rd_nxt; s1_pal_r <= s1_pal_nxt;
      s1_src_r <= s1_src_nxt; s1_lwe_r <= s1_lwe_nxt; s1_lidx_r <= s1_lidx_nxt;
      s1_pv_r <= s1_pv_nxt; s1_col_r <= s1_col_nxt; s1_pos_r <= s1_pos_nxt;
      s1_nmi_r <= s1_nmi_nxt; s1_fd_r <= s1_fd_nxt;
    end
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready) else $error("request accepted during RAM clear");
  a_timing_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r <= 9'd340 && line_r <= 9'd261) else $error("dot or line out of range");
  a_nmi_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.nmi |-> out_rsp.frame_done) else $error("nmi without frame end");
  a_frame_nopix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.frame_done |-> !out_rsp.pixel_valid)
    else $error("pixel drawn at vblank start");

endmodule
